/* hdl/sacc_pkg.sv */
// Shared types, codes and helper functions of the cache tag controller.
package sacc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IDX_W      = 15;
  localparam int LFSR_W     = 16;
  localparam int AGE_W      = 3;
  localparam int COST_W     = 10;
  localparam int LAT_W      = 11;
  localparam int OUT_WAY_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LRU   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_COST     = 3'd5;

  localparam logic [3:0]        RST_OFFSET_BITS = 4'd6;
  localparam logic [3:0]        RST_INDEX_BITS  = 4'd6;
  localparam logic [3:0]        RST_WAYS        = 4'd4;
  localparam logic              RST_LRU         = 1'b1;
  localparam logic              RST_WT          = 1'b0;
  localparam logic [COST_W-1:0] RST_MISS_COST   = 10'd100;
  localparam logic [LFSR_W-1:0] LFSR_SEED       = 16'hACE1;
  localparam logic [AGE_W-1:0]  AGE_MAX         = 3'd7;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LINE,
    S_SPLIT,
    S_SMOD,
    S_META,
    S_SCAN,
    S_VICT,
    S_VMOD,
    S_WB
  } state_t;

  typedef enum logic [1:0] {
    FK_FREE,
    FK_LRU,
    FK_RAND
  } fill_t;

  typedef struct packed {
    logic             vld;
    logic [AGE_W-1:0] age;
  } meta_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    return (a < AGE_MAX) ? a + 1'b1 : AGE_MAX;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_adv(input logic [LFSR_W-1:0] l);
    logic b;
    b = l[0] ^ l[2] ^ l[3] ^ l[5];
    return {b, l[LFSR_W-1:1]};
  endfunction

endpackage

/* hdl/set_assoc_cache_tag_controller_top.sv */
// Top level of the set-associative cache tag and replacement controller.
//
//   channel  ports                                    handshake
//   input    in_op, in_addr                           start & !busy
//   result   out_hit, out_latency, out_filled, out_way  out_valid, one cycle
//   config   cfg_idx, cfg_wdata                       cfg_we, no wait
//
// An access keeps busy high in S_LINE, S_SPLIT, S_SMOD, S_META, S_SCAN for each way scanned,
// S_VICT on a miss and S_WB; the set index reduction by SETS is a reciprocal multiply within them.
// A random fill into a full set adds S_VMOD, which waits for the remainder unit.
// The way scan reads one tag per cycle from the tag RAM.
// After reset busy stays high for a clearing pass that zeroes every metadata RAM entry.
// The result word is strobed in the first cycle with busy low; it cannot be stalled.
module set_assoc_cache_tag_controller_top #(
  parameter int WAYS      = 8,
  parameter int SETS      = 1024,
  parameter int ADDR_BITS = 48
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_op,
  input  logic [ADDR_BITS-1:0]               in_addr,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [sacc_pkg::LAT_W-1:0]         out_latency,
  output logic                               out_filled,
  output logic [sacc_pkg::OUT_WAY_W-1:0]     out_way,
  input  logic                               cfg_we,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W  = $clog2(WAYS);
  localparam int NW_W   = $clog2(WAYS + 1);
  localparam int DVS_W  = NW_W;
  localparam int DVD_W  = sacc_pkg::LFSR_W;
  localparam int META_W = WAYS * $bits(sacc_pkg::meta_t);
  localparam int TAG_W  = ADDR_BITS;
  localparam int RCP_S  = sacc_pkg::IDX_W;
  localparam int RCP_W  = RCP_S + 1;
  localparam int PROD_W = sacc_pkg::IDX_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_K =
    RCP_W'((longint'(1) << RCP_S) / longint'(SETS));
  localparam logic [sacc_pkg::IDX_W-1:0] SETS_K = sacc_pkg::IDX_W'(SETS);

  // configuration
  logic [3:0]                    offs_r, idxb_r, ways_r;
  logic                          lru_r, wt_r;
  logic [sacc_pkg::COST_W-1:0]   cost_r;
  logic [NW_W-1:0]               nw;

  // sequencer
  sacc_pkg::state_t              state_r, state_nxt;
  sacc_pkg::fill_t               kind_r, kind_nxt;
  logic [SET_W-1:0]              clr_r, clr_nxt;
  logic                          op_r, op_nxt;
  logic [ADDR_BITS-1:0]          addr_r, addr_nxt;
  logic [ADDR_BITS-1:0]          line_r, line_nxt;
  logic [TAG_W-1:0]              tag_r, tag_nxt;
  logic [SET_W-1:0]              set_r, set_nxt;
  logic [sacc_pkg::IDX_W-1:0]    quot_r, quot_nxt;
  logic [WAY_W-1:0]              scan_r, scan_nxt;
  logic                          inv_fnd_r, inv_fnd_nxt;
  logic [WAY_W-1:0]              inv_w_r, inv_w_nxt;
  logic [WAY_W-1:0]              max_w_r, max_w_nxt;
  logic [sacc_pkg::AGE_W-1:0]    max_age_r, max_age_nxt;
  logic                          hit_r, hit_nxt;
  logic                          fill_r, fill_nxt;
  logic [WAY_W-1:0]              hw_r, hw_nxt;
  logic [WAY_W-1:0]              fw_r, fw_nxt;
  logic [sacc_pkg::LFSR_W-1:0]   lfsr_r, lfsr_nxt;

  // result word
  logic                          ov_r, ov_nxt;
  logic                          ohit_r, ohit_nxt;
  logic [sacc_pkg::LAT_W-1:0]    olat_r, olat_nxt;
  logic                          ofill_r, ofill_nxt;
  logic [sacc_pkg::OUT_WAY_W-1:0] oway_r, oway_nxt;

  // memories and remainder unit
  logic                          meta_we;
  logic [SET_W-1:0]              meta_wa;
  logic [META_W-1:0]             meta_wd, meta_rd;
  sacc_pkg::meta_t [WAYS-1:0]    meta_q, meta_new;
  logic                          tag_we;
  logic [SET_W+WAY_W-1:0]        tag_ra;
  logic [TAG_W-1:0]              tag_q;
  logic                          rem_go, rem_done;
  logic [DVD_W-1:0]              rem_dvd;
  logic [DVS_W-1:0]              rem_dvs, rem_q;

  logic [sacc_pkg::IDX_W-1:0]    idx_raw;
  logic [PROD_W-1:0]             rcp_prod;
  logic [sacc_pkg::IDX_W-1:0]    red;
  sacc_pkg::meta_t               cur;
  logic [sacc_pkg::AGE_W-1:0]    old_age;
  logic [sacc_pkg::LFSR_W-1:0]   lfsr_step;
  logic [WAY_W-1:0]              way_sel;

  always_comb begin
    if (ways_r == '0) begin
      nw = NW_W'(1);
    end else if (int'(ways_r) > WAYS) begin
      nw = NW_W'(WAYS);
    end else begin
      nw = NW_W'(ways_r);
    end
  end

  assign idx_raw   = line_r[sacc_pkg::IDX_W-1:0] & ~({sacc_pkg::IDX_W{1'b1}} << idxb_r);
  // quotient estimate is exact or one low; one compare and subtract finishes it
  assign rcp_prod  = PROD_W'(idx_raw) * PROD_W'(RCP_K);
  assign red       = idx_raw - sacc_pkg::IDX_W'(quot_r * SETS_K);
  assign meta_q    = meta_rd;
  assign cur       = meta_q[scan_r];
  assign old_age   = meta_q[hw_r].age;
  assign lfsr_step = sacc_pkg::lfsr_adv(lfsr_r);
  assign way_sel   = hit_r ? hw_r : (fill_r ? fw_r : '0);

  // new ages and valid bits of the set
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      meta_new[w] = meta_q[w];
      if (NW_W'(w) < nw) begin
        if (hit_r) begin
          if (meta_q[w].vld && meta_q[w].age < old_age) begin
            meta_new[w].age = sacc_pkg::age_inc(meta_q[w].age);
          end
          if (WAY_W'(w) == hw_r) begin
            meta_new[w].age = '0;
          end
        end else if (fill_r) begin
          case (kind_r)
            sacc_pkg::FK_FREE: begin
              if (meta_q[w].vld) begin
                meta_new[w].age = sacc_pkg::age_inc(meta_q[w].age);
              end
            end
            sacc_pkg::FK_LRU: begin
              meta_new[w].age = sacc_pkg::age_inc(meta_q[w].age);
            end
            default: begin
            end
          endcase
          if (WAY_W'(w) == fw_r) begin
            meta_new[w].vld = 1'b1;
            meta_new[w].age = '0;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    clr_nxt     = clr_r;
    op_nxt      = op_r;
    addr_nxt    = addr_r;
    line_nxt    = line_r;
    tag_nxt     = tag_r;
    set_nxt     = set_r;
    quot_nxt    = quot_r;
    scan_nxt    = scan_r;
    inv_fnd_nxt = inv_fnd_r;
    inv_w_nxt   = inv_w_r;
    max_w_nxt   = max_w_r;
    max_age_nxt = max_age_r;
    hit_nxt     = hit_r;
    fill_nxt    = fill_r;
    hw_nxt      = hw_r;
    fw_nxt      = fw_r;
    lfsr_nxt    = lfsr_r;
    ov_nxt      = 1'b0;
    ohit_nxt    = ohit_r;
    olat_nxt    = olat_r;
    ofill_nxt   = ofill_r;
    oway_nxt    = oway_r;
    meta_we     = 1'b0;
    meta_wa     = set_r;
    meta_wd     = meta_new;
    tag_we      = 1'b0;
    tag_ra      = {set_r, WAY_W'(scan_r + 1'b1)};
    rem_go      = 1'b0;
    rem_dvd     = '0;
    rem_dvs     = '0;

    unique case (state_r)
      sacc_pkg::S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = clr_r;
        meta_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = sacc_pkg::S_IDLE;
        end
      end
      sacc_pkg::S_IDLE: begin
        if (start) begin
          op_nxt    = in_op;
          addr_nxt  = in_addr;
          state_nxt = sacc_pkg::S_LINE;
        end
      end
      sacc_pkg::S_LINE: begin
        line_nxt  = addr_r >> offs_r;
        state_nxt = sacc_pkg::S_SPLIT;
      end
      sacc_pkg::S_SPLIT: begin
        tag_nxt   = line_r >> idxb_r;
        quot_nxt  = sacc_pkg::IDX_W'(rcp_prod >> RCP_S);
        state_nxt = sacc_pkg::S_SMOD;
      end
      sacc_pkg::S_SMOD: begin
        set_nxt   = (red >= SETS_K) ? SET_W'(red - SETS_K) : SET_W'(red);
        state_nxt = sacc_pkg::S_META;
      end
      sacc_pkg::S_META: begin
        tag_ra      = {set_r, WAY_W'(0)};
        scan_nxt    = '0;
        inv_fnd_nxt = 1'b0;
        inv_w_nxt   = '0;
        max_w_nxt   = '0;
        max_age_nxt = '0;
        hit_nxt     = 1'b0;
        fill_nxt    = 1'b0;
        hw_nxt      = '0;
        fw_nxt      = '0;
        state_nxt   = sacc_pkg::S_SCAN;
      end
      sacc_pkg::S_SCAN: begin
        if (cur.vld && tag_q == tag_r) begin
          hit_nxt   = 1'b1;
          hw_nxt    = scan_r;
          state_nxt = sacc_pkg::S_WB;
        end else begin
          if (!cur.vld && !inv_fnd_r) begin
            inv_fnd_nxt = 1'b1;
            inv_w_nxt   = scan_r;
          end
          if (scan_r == '0 || cur.age > max_age_r) begin
            max_w_nxt   = scan_r;
            max_age_nxt = cur.age;
          end
          if (NW_W'(scan_r) == nw - 1'b1) begin
            state_nxt = sacc_pkg::S_VICT;
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      sacc_pkg::S_VICT: begin
        if (op_r && wt_r) begin
          state_nxt = sacc_pkg::S_WB;
        end else begin
          fill_nxt = 1'b1;
          if (inv_fnd_r) begin
            fw_nxt    = inv_w_r;
            kind_nxt  = sacc_pkg::FK_FREE;
            state_nxt = sacc_pkg::S_WB;
          end else if (lru_r) begin
            fw_nxt    = max_w_r;
            kind_nxt  = sacc_pkg::FK_LRU;
            state_nxt = sacc_pkg::S_WB;
          end else begin
            lfsr_nxt  = lfsr_step;
            rem_go    = 1'b1;
            rem_dvd   = lfsr_step;
            rem_dvs   = DVS_W'(nw);
            kind_nxt  = sacc_pkg::FK_RAND;
            state_nxt = sacc_pkg::S_VMOD;
          end
        end
      end
      sacc_pkg::S_VMOD: begin
        if (rem_done) begin
          fw_nxt    = WAY_W'(rem_q);
          state_nxt = sacc_pkg::S_WB;
        end
      end
      sacc_pkg::S_WB: begin
        meta_we   = hit_r || fill_r;
        tag_we    = fill_r;
        ov_nxt    = 1'b1;
        ohit_nxt  = hit_r;
        ofill_nxt = fill_r;
        oway_nxt  = sacc_pkg::OUT_WAY_W'(way_sel);
        olat_nxt  = sacc_pkg::LAT_W'(1)
                  + (op_r ? sacc_pkg::LAT_W'(cost_r) : '0)
                  + (fill_r ? sacc_pkg::LAT_W'(cost_r) : '0);
        state_nxt = sacc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sacc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacc_pkg::S_CLEAR;
      clr_r   <= '0;
      lfsr_r  <= sacc_pkg::LFSR_SEED;
      ov_r    <= 1'b0;
      offs_r  <= sacc_pkg::RST_OFFSET_BITS;
      idxb_r  <= sacc_pkg::RST_INDEX_BITS;
      ways_r  <= sacc_pkg::RST_WAYS;
      lru_r   <= sacc_pkg::RST_LRU;
      wt_r    <= sacc_pkg::RST_WT;
      cost_r  <= sacc_pkg::RST_MISS_COST;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      lfsr_r  <= lfsr_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          sacc_pkg::CFG_OFFSET_BITS:   offs_r <= cfg_wdata[3:0];
          sacc_pkg::CFG_INDEX_BITS:    idxb_r <= cfg_wdata[3:0];
          sacc_pkg::CFG_WAYS_IN_USE:   ways_r <= cfg_wdata[3:0];
          sacc_pkg::CFG_REPLACE_LRU:   lru_r  <= cfg_wdata[0];
          sacc_pkg::CFG_WRITE_THROUGH: wt_r   <= cfg_wdata[0];
          sacc_pkg::CFG_MISS_COST:     cost_r <= cfg_wdata[sacc_pkg::COST_W-1:0];
          default: begin
          end
        endcase
      end
    end
    kind_r    <= kind_nxt;
    op_r      <= op_nxt;
    addr_r    <= addr_nxt;
    line_r    <= line_nxt;
    tag_r     <= tag_nxt;
    set_r     <= set_nxt;
    quot_r    <= quot_nxt;
    scan_r    <= scan_nxt;
    inv_fnd_r <= inv_fnd_nxt;
    inv_w_r   <= inv_w_nxt;
    max_w_r   <= max_w_nxt;
    max_age_r <= max_age_nxt;
    hit_r     <= hit_nxt;
    fill_r    <= fill_nxt;
    hw_r      <= hw_nxt;
    fw_r      <= fw_nxt;
    ohit_r    <= ohit_nxt;
    olat_r    <= olat_nxt;
    ofill_r   <= ofill_nxt;
    oway_r    <= oway_nxt;
  end

  sacc_ram #(
    .WIDTH (META_W),
    .DEPTH (2 ** SET_W)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_wa),
    .wdata (meta_wd),
    .raddr (set_r),
    .rdata (meta_rd)
  );

  sacc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (2 ** (SET_W + WAY_W))
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr ({set_r, fw_r}),
    .wdata (tag_r),
    .raddr (tag_ra),
    .rdata (tag_q)
  );

  sacc_rem #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (rem_go),
    .dvd   (rem_dvd),
    .dvs   (rem_dvs),
    .done  (rem_done),
    .rem   (rem_q)
  );

  assign busy        = (state_r != sacc_pkg::S_IDLE);
  assign out_valid   = ov_r;
  assign out_hit     = ohit_r;
  assign out_latency = olat_r;
  assign out_filled  = ofill_r;
  assign out_way     = oway_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_hit_no_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_filled))
    else $error("hit and fill reported together");

  a_idle_way: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit && !out_filled) |-> out_way == '0)
    else $error("way nonzero with neither hit nor fill");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_lat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_latency != '0)
    else $error("zero latency reported");

endmodule

/* hdl/sacc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/sacc_rem.sv */
// Iterative restoring remainder unit, one dividend bit per cycle.
module sacc_rem #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dvd,
  input  logic [DVS_W-1:0] dvs,
  output logic             done,
  output logic [DVS_W-1:0] rem
);

  localparam int CW    = (DVD_W > DVS_W) ? DVD_W : DVS_W;
  localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [CW-1:0]    dvd_x, dvs_x;
  logic [DVS_W:0]   trial;

  assign dvd_x = CW'(dvd);
  assign dvs_x = CW'(dvs);
  assign trial = {rem_r, dvd_r[DVD_W-1]};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (go) begin
      if (dvd_x < dvs_x) begin
        rem_nxt  = DVS_W'(dvd_x);
        done_nxt = 1'b1;
      end else begin
        run_nxt = 1'b1;
        cnt_nxt = CNT_W'(DVD_W - 1);
        dvd_nxt = dvd;
        dvs_nxt = dvs;
        rem_nxt = '0;
      end
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = DVS_W'(trial);
      end
      dvd_nxt = dvd_r << 1;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
